@@ rtl/lpe_pkg.sv @@
// Shared types, register indexes and reset values for the LSB payload extractor.
// No dependencies; every other file in rtl/ imports this package.
package lpe_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_CHANNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES    = 3'd4;

    // Pixel formats
    localparam logic [1:0] FMT_RGBA16 = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_RGBA32 = 2'd2;

    localparam logic [3:0] BITS_RESET   = 4'd2;
    localparam logic [1:0] FORMAT_RESET = FMT_RGB24;

    // Default depth of the result queue
    localparam int RES_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [3:0]  bits_per_channel;
        logic [1:0]  pixel_format;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [31:0] payload_bytes;
    } cfg_t;

    // Red sits in the lowest byte, as on s_tdata
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic       capacity_error;
        logic       is_last;
        logic [7:0] payload_byte;
    } result_t;

    // Up to two results per pixel toward the result queue
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

@@ rtl/lpe_capacity.sv @@
// Capacity check: compares the payload length against the image capacity.
// Depends on lpe_pkg (cfg_t, format codes).
module lpe_capacity (
    input  logic          aclk,
    input  logic          aresetn,
    input  lpe_pkg::cfg_t cfg,
    output logic          cap_err
);
    import lpe_pkg::*;

    logic [31:0] area_reg;
    logic [31:0] area_next;
    logic [2:0]  factor;
    logic [4:0]  bits_factor;
    logic [36:0] cap_bits;
    logic [33:0] cap_bytes;

    // Register the pixel count so only a small multiply follows it
    assign area_next = 32'(cfg.image_width) * 32'(cfg.image_height);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_reg <= '0;
        end else begin
            area_reg <= area_next;
        end
    end

    always_comb begin
        factor = 3'd0;
        case (cfg.pixel_format)
            FMT_RGBA16: if (cfg.bits_per_channel < 4'd3) factor = 3'd4;
            FMT_RGB24:  if (cfg.bits_per_channel < 4'd5) factor = 3'd3;
            FMT_RGBA32: if (cfg.bits_per_channel < 4'd5) factor = 3'd4;
            default:    factor = 3'd0;
        endcase
    end

    // factor is 3 or 4 only when bits is at most 4, so the product fits 5 bits
    always_comb begin
        case (factor)
            3'd3:    bits_factor = 5'(cfg.bits_per_channel[2:0]) +
                                   5'({cfg.bits_per_channel[2:0], 1'b0});
            3'd4:    bits_factor = 5'({cfg.bits_per_channel[2:0], 2'b00});
            default: bits_factor = 5'd0;
        endcase
    end

    assign cap_bits  = 37'(area_reg) * 37'(bits_factor);
    assign cap_bytes = cap_bits[36:3];
    assign cap_err   = {2'b00, cfg.payload_bytes} > cap_bytes;

endmodule

@@ rtl/lpe_extract.sv @@
// Pixel register, bit gathering and payload byte assembly with its state.
// Depends on lpe_pkg (cfg_t, pixel_t, push_t, format codes).
module lpe_extract (
    input  logic           aclk,
    input  logic           aresetn,
    input  lpe_pkg::cfg_t  cfg,
    input  logic           cfg_busy,
    input  logic           cap_err,
    input  logic           room_two,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,
    input  logic           s_tuser,
    output lpe_pkg::push_t push
);
    import lpe_pkg::*;

    logic        p_valid_reg;
    logic        p_sof_reg;
    pixel_t      p_pix_reg;

    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] given_reg, given_next;
    logic        fin_reg, fin_next;

    logic [7:0]  acc_c;
    logic [2:0]  fill_c;
    logic [31:0] given_c;
    logic        fin_c;

    logic        advance;
    logic        use_alpha;
    logic [7:0]  alpha_c;
    logic [15:0] pix_bits;
    logic [4:0]  nbits;
    logic [4:0]  total;
    logic [22:0] combined;
    logic [1:0]  nbytes;
    logic [31:0] remaining;
    logic        last0;
    logic        last1;

    assign advance  = p_valid_reg && room_two;
    assign s_tready = (!p_valid_reg || advance) && !cfg_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            p_valid_reg <= 1'b1;
        end else if (advance) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            p_sof_reg <= s_tuser;
            p_pix_reg <= pixel_t'(s_tdata);
        end
    end

    // Start of image clears the state before this pixel is used
    assign acc_c   = p_sof_reg ? 8'd0  : acc_reg;
    assign fill_c  = p_sof_reg ? 3'd0  : fill_reg;
    assign given_c = p_sof_reg ? 32'd0 : given_reg;
    assign fin_c   = p_sof_reg ? 1'b0  : fin_reg;

    assign use_alpha = (cfg.pixel_format == FMT_RGBA16) || (cfg.pixel_format == FMT_RGBA32);
    assign alpha_c   = use_alpha ? p_pix_reg.alpha : 8'd0;

    // Low bits of each channel, red first, packed LSB first
    always_comb begin
        pix_bits = '0;
        case (cfg.bits_per_channel)
            4'd1: pix_bits[3:0]  = {alpha_c[0], p_pix_reg.blue[0],
                                    p_pix_reg.green[0], p_pix_reg.red[0]};
            4'd2: pix_bits[7:0]  = {alpha_c[1:0], p_pix_reg.blue[1:0],
                                    p_pix_reg.green[1:0], p_pix_reg.red[1:0]};
            4'd3: pix_bits[11:0] = {alpha_c[2:0], p_pix_reg.blue[2:0],
                                    p_pix_reg.green[2:0], p_pix_reg.red[2:0]};
            4'd4: pix_bits[15:0] = {alpha_c[3:0], p_pix_reg.blue[3:0],
                                    p_pix_reg.green[3:0], p_pix_reg.red[3:0]};
            default: pix_bits = '0;
        endcase
    end

    assign nbits = use_alpha ? 5'({cfg.bits_per_channel[2:0], 2'b00})
                             : 5'(cfg.bits_per_channel[2:0]) +
                               5'({cfg.bits_per_channel[2:0], 1'b0});
    assign total     = 5'(fill_c) + nbits;
    assign combined  = 23'(acc_c) | (23'(pix_bits) << fill_c);
    assign nbytes    = total[4:3];
    assign remaining = cfg.payload_bytes - given_c;
    assign last0     = remaining == 32'd1;
    assign last1     = remaining == 32'd2;

    always_comb begin
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        given_next = given_reg;
        fin_next   = fin_reg;
        push       = '0;
        if (advance) begin
            acc_next   = acc_c;
            fill_next  = fill_c;
            given_next = given_c;
            fin_next   = fin_c;
            if (!fin_c) begin
                if (cap_err) begin
                    push.push0 = 1'b1;
                    push.res0  = '{capacity_error: 1'b1, is_last: 1'b1, payload_byte: 8'd0};
                    fin_next   = 1'b1;
                end else if (given_c >= cfg.payload_bytes) begin
                    fin_next = 1'b1;
                end else if (nbytes == 2'd0) begin
                    acc_next  = combined[7:0];
                    fill_next = total[2:0];
                end else begin
                    push.push0 = 1'b1;
                    push.res0  = '{capacity_error: 1'b0, is_last: last0,
                                   payload_byte: combined[7:0]};
                    given_next = given_c + 32'd1;
                    acc_next   = combined[15:8];
                    fill_next  = total[2:0];
                    if (last0) begin
                        // drop the rest of this pixel
                        fin_next  = 1'b1;
                        acc_next  = 8'd0;
                        fill_next = 3'd0;
                    end else if (nbytes != 2'd1) begin
                        push.push1 = 1'b1;
                        push.res1  = '{capacity_error: 1'b0, is_last: last1,
                                       payload_byte: combined[15:8]};
                        given_next = given_c + 32'd2;
                        acc_next   = {1'b0, combined[22:16]};
                        if (last1) begin
                            fin_next  = 1'b1;
                            acc_next  = 8'd0;
                            fill_next = 3'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            fill_reg  <= '0;
            given_reg <= '0;
            fin_reg   <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            given_reg <= given_next;
            fin_reg   <= fin_next;
        end
    end

    a_err_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cap_err && !fin_c) |=> fin_reg)
        else $error("capacity error did not finish the image");

    a_finished_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fin_reg && !p_sof_reg) |-> !push.push0)
        else $error("result produced after the image finished");

endmodule

@@ rtl/lpe_result_fifo.sv @@
// Small result queue: takes up to two results a cycle, gives one a cycle while m_tready is high.
// Depends on lpe_pkg (push_t, result_t).
module lpe_result_fifo #(
    parameter int DEPTH = lpe_pkg::RES_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  lpe_pkg::push_t push,
    output logic           room_two,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import lpe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_one;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    result_t          head;

    function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = head.payload_byte;
    assign m_tlast  = head.is_last;
    assign m_tuser  = head.capacity_error;
    assign pop      = m_tvalid && m_tready;

    // Room for two after this cycle's pop
    assign room_two = ({1'b0, count_reg} + (CNT_W+1)'(2)) <=
                      ((CNT_W+1)'(DEPTH) + (CNT_W+1)'(pop));

    assign wr_ptr_one  = inc_ptr(wr_ptr_reg);
    assign wr_ptr_next = push.push1 ? inc_ptr(wr_ptr_one) :
                         push.push0 ? wr_ptr_one : wr_ptr_reg;
    assign rd_ptr_next = pop ? inc_ptr(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) -
                         CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.push1) begin
            mem[wr_ptr_one] <= push.res1;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push1 |-> push.push0)
        else $error("second result pushed without the first");

    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push0 && count_reg == '0) |=> m_tvalid)
        else $error("pushed result not presented");

endmodule

@@ rtl/lsb_payload_extractor.sv @@
// Top level of the LSB payload extractor: configuration registers and wiring.
// Depends on lpe_pkg, lpe_capacity, lpe_extract and lpe_result_fifo.
//
// Usage:
//   Pixels enter on the s_ channel, one transaction per pixel; s_tuser marks
//   the first pixel of an image and clears the extraction state. Recovered
//   payload bytes leave on the m_ channel; m_tlast marks the final byte of
//   the payload, and m_tuser marks the single error transaction given when
//   the payload does not fit the image (that transaction also has m_tlast).
//   Registers are written through cfg_we/cfg_index/cfg_wdata while no pixel
//   is in flight; s_tready drops for the cycle of a write so the capacity
//   product can settle.
// Timing:
//   A pixel accepted on s_ lands in the pixel register, is processed once
//   the queue has room for two results, and its bytes then pass through
//   the result queue to m_. One pixel is taken per cycle while s_tready
//   is high; the result port gives one byte per cycle while m_tready is
//   high, so pixels carrying more than 8 payload bits are limited by it.
// Reset and stall:
//   aresetn (synchronous, active low) restores register defaults and empties
//   the queue. When m_tready is low, results wait in the queue; s_tready
//   drops once the queue cannot take two more results.
module lsb_payload_extractor #(
    parameter int RES_DEPTH = lpe_pkg::RES_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // red, green, blue, alpha
    input  logic                           s_tuser,  // start_of_image
    // payload output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // payload_byte
    output logic                           m_tlast,  // is_last
    output logic                           m_tuser   // capacity_error
);
    import lpe_pkg::*;

    cfg_t  cfg_reg;
    logic  cap_err;
    logic  room_two;
    push_t push;

    // Hold register values; out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bits_per_channel <= BITS_RESET;
            cfg_reg.pixel_format     <= FORMAT_RESET;
            cfg_reg.image_width      <= '0;
            cfg_reg.image_height     <= '0;
            cfg_reg.payload_bytes    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BITS_PER_CHANNEL: cfg_reg.bits_per_channel <= cfg_wdata[3:0];
                REG_PIXEL_FORMAT:     cfg_reg.pixel_format     <= cfg_wdata[1:0];
                REG_IMAGE_WIDTH:      cfg_reg.image_width      <= cfg_wdata[15:0];
                REG_IMAGE_HEIGHT:     cfg_reg.image_height     <= cfg_wdata[15:0];
                REG_PAYLOAD_BYTES:    cfg_reg.payload_bytes    <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Capacity compare against the current image geometry
    lpe_capacity u_capacity (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cap_err (cap_err)
    );

    // Pixel register and byte assembly
    lpe_extract u_extract (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cfg_busy (cfg_we),
        .cap_err  (cap_err),
        .room_two (room_two),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push)
    );

    // Result queue decouples the two-bytes-per-pixel case from the port
    lpe_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room_two (room_two),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/lpe_checker.sv @@
// Scoreboard for the LSB payload extractor: watches the config port and both
// stream channels, predicts each payload byte and compares it. Needs lpe_pkg.
module lpe_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser,
    output int                             fail_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    cfg_t        regs;
    logic [7:0]  acc;
    int          fill;
    logic [31:0] bytes_out;
    logic        image_done;
    int          failures;
    result_t     expected_bytes_q[$];

    function automatic logic [63:0] capacity_of(cfg_t c);
        logic [63:0] factor;
        factor = 64'd0;
        case (c.pixel_format)
            FMT_RGBA16: if (c.bits_per_channel < 3) factor = 64'd4;
            FMT_RGB24:  if (c.bits_per_channel < 5) factor = 64'd3;
            FMT_RGBA32: if (c.bits_per_channel < 5) factor = 64'd4;
            default: factor = 64'd0;
        endcase
        return (factor * c.bits_per_channel * c.image_width * c.image_height) / 8;
    endfunction

    task automatic clear_image();
        acc        = '0;
        fill       = 0;
        bytes_out  = '0;
        image_done = 1'b0;
    endtask

    // Work out the bytes one accepted pixel gives and queue them.
    task automatic extract_pixel(input logic sof, input pixel_t px);
        logic [7:0] chan [4];
        int         nchan;
        result_t    res;
        if (sof) clear_image();
        if (image_done) return;
        if ({32'd0, regs.payload_bytes} > capacity_of(regs)) begin
            res.payload_byte   = 8'd0;
            res.is_last        = 1'b1;
            res.capacity_error = 1'b1;
            expected_bytes_q.push_back(res);
            image_done = 1'b1;
            return;
        end
        if (bytes_out >= regs.payload_bytes) begin
            image_done = 1'b1;
            return;
        end
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        chan[3] = px.alpha;
        nchan = (regs.pixel_format == FMT_RGBA16 || regs.pixel_format == FMT_RGBA32) ? 4 : 3;
        for (int c = 0; c < nchan; c++) begin
            for (int b = 0; b < regs.bits_per_channel && b < 8; b++) begin
                acc[fill] = chan[c][b];
                fill++;
                if (fill == 8) begin
                    bytes_out++;
                    res.payload_byte   = acc;
                    res.is_last        = (bytes_out >= regs.payload_bytes);
                    res.capacity_error = 1'b0;
                    expected_bytes_q.push_back(res);
                    acc  = '0;
                    fill = 0;
                    // drop the rest of the pixel once the payload is complete
                    if (res.is_last) begin
                        image_done = 1'b1;
                        return;
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            regs.bits_per_channel = BITS_RESET;
            regs.pixel_format     = FORMAT_RESET;
            regs.image_width      = '0;
            regs.image_height     = '0;
            regs.payload_bytes    = '0;
            clear_image();
            expected_bytes_q.delete();
            failures = 0;
        end else begin
            // compare first: a byte leaving now never belongs to a pixel entering now
            if (m_tvalid && m_tready) begin
                if (expected_bytes_q.size() == 0) begin
                    $error("unexpected payload transaction: byte %0h last %0b error %0b",
                           m_tdata, m_tlast, m_tuser);
                    failures++;
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (m_tdata !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.payload_byte, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("is_last: expected %0b, actual %0b", want.is_last, m_tlast);
                        failures++;
                    end
                    if (m_tuser !== want.capacity_error) begin
                        $error("capacity_error: expected %0b, actual %0b",
                               want.capacity_error, m_tuser);
                        failures++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BITS_PER_CHANNEL: regs.bits_per_channel = cfg_wdata[3:0];
                    REG_PIXEL_FORMAT:     regs.pixel_format     = cfg_wdata[1:0];
                    REG_IMAGE_WIDTH:      regs.image_width      = cfg_wdata[15:0];
                    REG_IMAGE_HEIGHT:     regs.image_height     = cfg_wdata[15:0];
                    REG_PAYLOAD_BYTES:    regs.payload_bytes    = cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) extract_pixel(s_tuser, pixel_t'(s_tdata));
        end
        pending_count <= expected_bytes_q.size();
        fail_count    <= failures;
    end

endmodule

@@ tb/tb_lsb_payload_extractor.sv @@
// Top of the LSB payload extractor testbench: clock, reset, pixel stimulus,
// config writes and the verdict. Needs lpe_pkg, lpe_checker and the RTL.
module tb_lsb_payload_extractor;
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    localparam int          RANDOM_PIXELS   = 550;
    localparam int          CYCLE_LIMIT     = 400000;
    // leave margin after the queue drains before touching the registers
    localparam int          SETTLE_CYCLES   = 4;
    localparam logic [1:0]  FMT_UNSUPPORTED = 2'd3;
    // idle phases: none, sender only, receiver only, both
    localparam int          SENDER_IDLE [4]    = '{0, 72, 0, 28};
    localparam int          RECEIVER_STALL [4] = '{0, 0, 72, 28};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // red, green, blue, alpha
    logic                  s_tuser;   // start_of_image
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // payload_byte
    logic                  m_tlast;   // is_last
    logic                  m_tuser;   // capacity_error

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    always #6 aclk = ~aclk;

    lsb_payload_extractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    lpe_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Receiver: stall at the rate of the current phase, one decision per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drop valid and hold until every predicted byte has left, then let the
    // pipeline settle so a pixel that gave no byte is also done.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all five registers back to back, only with the block idle.
    task automatic program_regs(input logic [3:0] bits, input logic [1:0] fmt,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [31:0] pl);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idx [5];
        vals = '{CFG_DATA_W'(bits), CFG_DATA_W'(fmt), CFG_DATA_W'(w), CFG_DATA_W'(h), pl};
        idx  = '{REG_BITS_PER_CHANNEL, REG_PIXEL_FORMAT, REG_IMAGE_WIDTH,
                 REG_IMAGE_HEIGHT, REG_PAYLOAD_BYTES};
        wait_for_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel after a random gap and hold it until the transaction.
    task automatic send_pixel(input logic sof, input logic [31:0] px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
    endtask

    // A run of random pixels, optionally opened by start_of_image; now and then
    // pause mid-image until the result side has drained.
    task automatic send_image(input int npix, input bit with_sof);
        for (int i = 0; i < npix; i++) begin
            if (i > 0 && $urandom_range(99) < 3) wait_for_idle();
            send_pixel(with_sof && i == 0, $urandom);
        end
    endtask

    initial begin
        int          sent;
        int          npix;
        int          nimg;
        int          bpp;
        int          kind;
        int          phase;
        logic [3:0]  bits;
        logic [1:0]  fmt;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] pl;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, no idling ----
        // empty payload with register defaults: nothing comes out
        send_pixel(1'b1, 32'h1234_5678);
        // full-size image still too small for the largest payload: one error,
        // then the finished image ignores further pixels
        program_regs(4'd1, FMT_RGB24, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(1'b1, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h0000_0000);
        // largest payload that fits: two bytes per pixel, all-ones and all-zeros
        program_regs(4'd4, FMT_RGBA32, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(1'b1, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h0000_0000);
        send_pixel(1'b0, 32'hA5C3_5A3C);
        // rgba16, short payload; the pixel after the last byte gives nothing
        program_regs(4'd2, FMT_RGBA16, 16'd2, 16'd2, 32'd2);
        send_pixel(1'b1, 32'hAA55_AA55);
        send_pixel(1'b0, 32'h55AA_55AA);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        // bit counts and formats with no capacity
        program_regs(4'd3, FMT_RGBA16, 16'd100, 16'd100, 32'd1);
        send_pixel(1'b1, 32'h0F0F_0F0F);
        program_regs(4'd8, FMT_RGB24, 16'd100, 16'd100, 32'd1);
        send_pixel(1'b1, 32'hF0F0_F0F0);
        program_regs(4'd0, FMT_RGBA32, 16'd100, 16'd100, 32'd1);
        send_pixel(1'b1, 32'h3333_3333);
        program_regs(4'd2, FMT_UNSUPPORTED, 16'd100, 16'd100, 32'd1);
        send_pixel(1'b1, 32'hCCCC_CCCC);
        // zero payload on zero capacity is an empty payload, not an error
        program_regs(4'd15, FMT_RGB24, 16'd0, 16'd0, 32'd0);
        send_pixel(1'b1, 32'h7777_7777);
        // payload ends inside a pixel; the leftover bit is dropped
        program_regs(4'd3, FMT_RGB24, 16'd10, 16'd10, 32'd1);
        send_pixel(1'b1, 32'h0506_0703);
        // change the bit count mid-image and carry on without start_of_image
        program_regs(4'd1, FMT_RGB24, 16'd8, 16'd8, 32'd3);
        send_pixel(1'b1, 32'h0001_0001);
        program_regs(4'd4, FMT_RGB24, 16'd8, 16'd8, 32'd3);
        send_pixel(1'b0, 32'h0009_0A0B);
        send_pixel(1'b0, 32'h000C_0D0E);
        // capacity exactly equal to the payload, then one byte over
        program_regs(4'd1, FMT_RGB24, 16'd8, 16'd1, 32'd3);
        send_pixel(1'b1, 32'h00FF_00FF);
        program_regs(4'd1, FMT_RGB24, 16'd8, 16'd1, 32'd4);
        send_pixel(1'b1, 32'h00FF_00FF);

        // ---- random part: mostly well-formed images, some broken setups ----
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            phase     = (sent * 4) / RANDOM_PIXELS;
            idle_pct  = SENDER_IDLE[phase];
            stall_pct = RECEIVER_STALL[phase];
            kind      = $urandom_range(99);
            fmt       = 2'($urandom_range(2, 0));
            bits      = (fmt == FMT_RGBA16) ? 4'($urandom_range(2, 1))
                                            : 4'($urandom_range(4, 1));
            w         = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(300, 8));
            h         = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(300, 8));
            pl        = $urandom_range(20, 1);
            if (kind >= 93) begin
                // huge random length on the largest image
                bits = 4'd4;
                w    = 16'hFFFF;
                h    = 16'hFFFF;
                pl   = $urandom;
            end else if (kind >= 85) begin
                // tiny image: capacity often just short
                w  = 16'($urandom_range(4));
                h  = 16'($urandom_range(4));
                pl = $urandom_range(8);
            end else if (kind >= 75) begin
                // bit count or format with no capacity
                bits = 4'($urandom_range(15));
                if (bits inside {[1:4]}) fmt = FMT_UNSUPPORTED;
                pl = $urandom_range(20);
            end
            program_regs(bits, fmt, w, h, pl);
            bpp  = bits * ((fmt == FMT_RGBA16 || fmt == FMT_RGBA32) ? 4 : 3);
            nimg = $urandom_range(3, 1);
            for (int k = 0; k < nimg; k++) begin
                if (bits inside {[1:4]} && pl <= 64)
                    npix = (pl * 8 + bpp - 1) / bpp + $urandom_range(2);
                else
                    npix = $urandom_range(12, 1);
                if (npix == 0) npix = 1;
                // the first image after a write sometimes continues the old one
                send_image(npix, !(k == 0 && $urandom_range(99) < 20));
                sent += npix;
            end
        end

        // ---- drain and verdict ----
        wait_for_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lpe_pkg.sv
rtl/lpe_capacity.sv
rtl/lpe_extract.sv
rtl/lpe_result_fifo.sv
rtl/lsb_payload_extractor.sv
tb/lpe_checker.sv
tb/tb_lsb_payload_extractor.sv
